// ===== sv/mlc_pkg.sv =====
// package: types and constants for the mesi cache line controller
package mlc_pkg;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_DOWNGR  = 3'd2,
    CMD_INVAL   = 3'd3,
    CMD_UPGRADE = 3'd4,
    CMD_PROBE   = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  localparam logic [0:0] REG_CACHE_ID = 1'd0;
  localparam logic [0:0] REG_UL_MASK  = 1'd1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic        directory_has_copy;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  line_state;
    logic        dir_req_valid;
    logic        dir_req_write;
    logic        evict_valid;
    logic        evict_dirty;
    logic [31:0] victim_address;
    logic        prev_inval_valid;
    logic [31:0] prev_inval_address;
    logic [31:0] prev_inval_mask;
    logic [7:0]  source_id;
    logic        error;
  } out_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

endpackage

// ===== sv/mlc_ctrl.sv =====
// controller: sequences capture, set read, update and result handshake
module mlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mlc_pkg::ctl_cmd_t cmd
);
  import mlc_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = FSM_LOOKUP;
        end
      end
      FSM_LOOKUP: begin
        cmd.commit = 1'b1;
        state_nxt  = FSM_OUT;
      end
      FSM_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = FSM_LOOKUP;
          end else begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end
endmodule

// ===== sv/mlc_datapath.sv =====
// datapath: set memories, hit and victim logic, lru update, result register
module mlc_datapath #(
  parameter int NUM_SETS   = 128,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mlc_pkg::ctl_cmd_t  cmd,
  input  mlc_pkg::in_item_t  in_data,
  input  logic [7:0]         cache_id,
  input  logic [31:0]        ul_mask,
  output mlc_pkg::out_item_t out_data
);
  import mlc_pkg::*;

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_B  = $clog2(NUM_SETS);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = (ADDR_BITS - OFF_W - SET_B > 0) ? ADDR_BITS - OFF_W - SET_B : 1;
  localparam int TAGS_W = TAG_W * NUM_WAYS;
  localparam int ST_W   = 2 * NUM_WAYS;
  localparam int AGE_W  = WAY_W * NUM_WAYS;
  localparam int IN_W   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [WAY_W-1:0] MAX_AGE = WAY_W'(NUM_WAYS - 1);

  // one row per set; state and ages cleared by per-set valid bits
  logic [TAGS_W-1:0] tag_mem [NUM_SETS];
  logic [ST_W-1:0]   st_mem  [NUM_SETS];
  logic [AGE_W-1:0]  age_mem [NUM_SETS];
  logic [NUM_SETS-1:0] set_vld_r;

  logic [ADDR_BITS-1:0] addr_r;
  logic [2:0]           cmd_r;
  logic                 dir_r;
  logic [TAGS_W-1:0]    tags_rd_r;
  logic [ST_W-1:0]      st_rd_r;
  logic [AGE_W-1:0]     age_rd_r;
  logic                 rd_vld_r;
  out_item_t            out_r;

  logic [ADDR_BITS-1:0] addr_in;
  logic [SET_W-1:0]     set_in, set_c;
  logic [TAG_W-1:0]     tag_c;

  always_comb begin
    addr_in = '0;
    addr_in[IN_W-1:0] = in_data.address[IN_W-1:0];
  end

  function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] a);
    logic [SET_W-1:0] s;
    s = '0;
    if (NUM_SETS > 1) s = SET_W'(a >> OFF_W);
    return s;
  endfunction

  assign set_in = set_of(addr_in);
  assign set_c  = set_of(addr_r);
  assign tag_c  = TAG_W'(addr_r >> (OFF_W + SET_B));

  // capture item and read its set
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r    <= addr_in;
      cmd_r     <= in_data.command;
      dir_r     <= in_data.directory_has_copy;
      tags_rd_r <= tag_mem[set_in];
      st_rd_r   <= st_mem[set_in];
      age_rd_r  <= age_mem[set_in];
      rd_vld_r  <= set_vld_r[set_in];
    end
  end

  logic [1:0]       st_w   [NUM_WAYS];
  logic [WAY_W-1:0] age_w  [NUM_WAYS];
  logic [TAG_W-1:0] tag_w  [NUM_WAYS];
  logic             found;
  logic [WAY_W-1:0] hway, vway, uway;
  logic [ST_W-1:0]  st_new;
  logic [AGE_W-1:0] age_new;
  logic [TAGS_W-1:0] tag_new;
  logic             touch_lru, wr_tag;
  out_item_t        res;
  logic [ADDR_BITS-1:0] vaddr;
  logic [1:0]       cur, vst;
  logic [WAY_W-1:0] ua;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_w[w] = tags_rd_r[w*TAG_W +: TAG_W];
      st_w[w]  = rd_vld_r ? st_rd_r[w*2 +: 2] : ST_I;
      age_w[w] = rd_vld_r ? age_rd_r[w*WAY_W +: WAY_W] : WAY_W'(w);
    end
    found = 1'b0;
    hway  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (st_w[w] != ST_I && tag_w[w] == tag_c) begin
        found = 1'b1;
        hway  = WAY_W'(w);
      end
    end
    vway = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (age_w[w] == '0) vway = WAY_W'(w);
    end
    cur   = st_w[hway];
    vst   = st_w[vway];
    vaddr = '0;
    vaddr = ADDR_BITS'(tag_w[vway]) << (OFF_W + SET_B);
    if (NUM_SETS > 1) vaddr = vaddr | (ADDR_BITS'(set_c) << OFF_W);

    res           = '0;
    res.source_id = cache_id;
    st_new        = '0;
    for (int w = 0; w < NUM_WAYS; w++) st_new[w*2 +: 2] = st_w[w];
    touch_lru = 1'b0;
    wr_tag    = 1'b0;
    uway      = hway;
    case (cmd_r)
      CMD_READ, CMD_WRITE: begin
        touch_lru = 1'b1;
        if (!found) begin
          uway   = vway;
          wr_tag = 1'b1;
          if (vst != ST_I) begin
            res.evict_valid        = 1'b1;
            res.evict_dirty        = (vst == ST_M);
            res.victim_address     = 32'(vaddr);
            res.prev_inval_valid   = 1'b1;
            res.prev_inval_address = 32'(vaddr);
            res.prev_inval_mask    = ul_mask;
          end
          res.dir_req_valid = 1'b1;
          res.dir_req_write = (cmd_r == CMD_WRITE);
          res.line_state    = (cmd_r == CMD_WRITE) ? ST_M : (dir_r ? ST_S : ST_E);
          st_new[vway*2 +: 2] = res.line_state;
        end else begin
          res.hit = 1'b1;
          res.line_state = cur;
          if (cmd_r == CMD_WRITE) begin
            if (cur == ST_S) begin
              res.dir_req_valid = 1'b1;
              res.dir_req_write = 1'b1;
            end
            res.line_state = ST_M;
          end
          st_new[hway*2 +: 2] = res.line_state;
        end
      end
      CMD_DOWNGR, CMD_INVAL, CMD_UPGRADE: begin
        if (!found) begin
          res.error = 1'b1;
        end else begin
          res.hit = 1'b1;
          res.line_state = cur;
          if (cmd_r == CMD_DOWNGR) begin
            res.line_state = ST_S;
          end else if (cmd_r == CMD_INVAL) begin
            res.line_state         = ST_I;
            res.prev_inval_valid   = 1'b1;
            res.prev_inval_address = 32'(addr_r);
            res.prev_inval_mask    = ul_mask;
          end else if (cur == ST_S) begin
            res.line_state = ST_E;
          end else begin
            res.error = 1'b1;
          end
          st_new[hway*2 +: 2] = res.line_state;
        end
      end
      CMD_PROBE: begin
        if (found) begin
          res.hit = 1'b1;
          res.line_state = cur;
        end else if (vst != ST_I) begin
          res.evict_valid    = 1'b1;
          res.evict_dirty    = (vst == ST_M);
          res.victim_address = 32'(vaddr);
        end
      end
      default: ;
    endcase

    // new tag row: refilled way takes the item's tag
    tag_new = tags_rd_r;
    if (wr_tag) tag_new[uway*TAG_W +: TAG_W] = tag_c;

    // true lru: ages above the touched way step down, touched way to top
    ua = age_w[uway];
    for (int w = 0; w < NUM_WAYS; w++) begin
      age_new[w*WAY_W +: WAY_W] = age_w[w];
      if (touch_lru && ua != MAX_AGE) begin
        if (WAY_W'(w) == uway) age_new[w*WAY_W +: WAY_W] = MAX_AGE;
        else if (age_w[w] > ua) age_new[w*WAY_W +: WAY_W] = age_w[w] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_mem[set_c]  <= st_new;
      age_mem[set_c] <= age_new;
      out_r          <= res;
      if (wr_tag) begin
        tag_mem[set_c] <= tag_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_vld_r <= '0;
    end else if (cmd.commit) begin
      set_vld_r[set_c] <= 1'b1;
    end
  end

  assign out_data = out_r;
endmodule

// ===== sv/mlc_regs.sv =====
// configuration registers behind the apb-style port
module mlc_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic [7:0]  cache_id,
  output logic [31:0] ul_mask
);
  import mlc_pkg::*;

  logic [7:0]  cache_id_r;
  logic [31:0] ul_mask_r;
  logic        wr;

  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_id_r <= '0;
      ul_mask_r  <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_CACHE_ID) cache_id_r <= cfg_pwdata[7:0];
      if (cfg_paddr[2] == REG_UL_MASK)  ul_mask_r  <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_CACHE_ID) cfg_prdata = {24'd0, cache_id_r};
      else cfg_prdata = ul_mask_r;
    end
  end

  assign cache_id = cache_id_r;
  assign ul_mask  = ul_mask_r;
endmodule

// ===== sv/mesi_cache_line_controller.sv =====
// top level: mesi cache line controller with true lru
// an accepted item passes capture+set read, then update, before its result is shown
// a new item waits while the one before it does the read-modify-write of its set row
// the next item is taken in the same cycle its predecessor's result is taken
// reset (rst_n, synchronous, low): all lines invalid, ages reset, registers zero
// no clearing pass: per-set valid bits stand in for the reset contents
module mesi_cache_line_controller #(
  parameter int NUM_SETS   = 128,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlc_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import mlc_pkg::*;

  ctl_cmd_t    cmd;
  logic [7:0]  cache_id;
  logic [31:0] ul_mask;

  // apb accesses always complete in their access cycle
  assign cfg_pready = 1'b1;

  mlc_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cache_id, .ul_mask
  );

  // sequencer: idle -> lookup -> result held until taken
  mlc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  // set memories and all the per-item coherence logic
  mlc_datapath #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .in_data, .cache_id, .ul_mask, .out_data
  );
endmodule

// ===== sv/mlc_checker.sv =====
// port-level checker for the mesi cache line controller, with its bind
module mlc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mlc_pkg::out_item_t out_data
);
  import mlc_pkg::*;

  // an accepted item brings a result once the lookup state has passed
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid) else $error("result missing");

  // no item taken while a result stalls
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall) else $error("accepted while stalled");

  // errors never come with a directory request or eviction
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> !(out_data.dir_req_valid || out_data.evict_valid))
    else $error("error with side effect");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data))) else $error("result dropped");
endmodule

bind mesi_cache_line_controller mlc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

// ===== tb/sv/tb_mesi_cache_line_controller.sv =====
// testbench: directed table and random traffic checked against a mesi cache predictor
`timescale 1ns / 1ps

module tb_mesi_cache_line_controller;
  import mlc_pkg::*;

  // command codes the block must treat as no-ops
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;
  // byte addresses of the registers on the config port
  localparam logic [2:0] ADDR_CACHE_ID = {REG_CACHE_ID, 2'b00};
  localparam logic [2:0] ADDR_UL_MASK  = {REG_UL_MASK, 2'b00};
  localparam int SETS = 128;
  localparam int WAYS = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 510;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mesi_cache_line_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the cache: tags, mesi states, lru ages, registers
  logic [18:0] line_tag [SETS][WAYS];
  logic [1:0]  line_st  [SETS][WAYS];
  logic [1:0]  line_age [SETS][WAYS];
  logic [7:0]  model_cache_id;
  logic [31:0] model_ul_mask;

  out_item_t pending_results[$];

  int  fail_count;
  int  items_sent;
  int  results_checked;
  int  hits_seen;
  int  evicts_seen;
  int  errors_seen;
  bit  no_idle;       // last phase: neither side idles
  bit  hold_req;      // ask the receiver for one long hold-off
  bit  accepted_any;  // some handshake completes at the coming edge
  int  idle_cycles;
  int  stall_left;

  // refresh ages so that way becomes most recently used
  function automatic void touch_way(int s, int w);
    logic [1:0] a;
    a = line_age[s][w];
    if (a == 2'(WAYS - 1)) return;
    for (int i = 0; i < WAYS; i++)
      if (line_age[s][i] > a) line_age[s][i]--;
    line_age[s][w] = 2'(WAYS - 1);
  endfunction

  // work out the result of one command and update the cache copy
  function automatic out_item_t mesi_predict(in_item_t it);
    out_item_t r;
    logic [6:0]  s;
    logic [18:0] t;
    int way;
    int vic;
    logic [31:0] va;
    r = '0;
    r.source_id = model_cache_id;
    s = it.address[12:6];
    t = it.address[31:13];
    way = WAYS;
    for (int w = WAYS - 1; w >= 0; w--)
      if (line_st[s][w] != ST_I && line_tag[s][w] == t) way = w;
    // victim: way of age 0, way 0 if none
    vic = 0;
    for (int w = WAYS - 1; w >= 0; w--)
      if (line_age[s][w] == 2'd0) vic = w;
    va = {line_tag[s][vic], s, 6'd0};
    case (it.command)
      CMD_READ, CMD_WRITE: begin
        if (way == WAYS) begin
          if (line_st[s][vic] != ST_I) begin
            r.evict_valid        = 1'b1;
            r.evict_dirty        = line_st[s][vic] == ST_M;
            r.victim_address     = va;
            r.prev_inval_valid   = 1'b1;
            r.prev_inval_address = va;
            r.prev_inval_mask    = model_ul_mask;
          end
          line_tag[s][vic] = t;
          line_st[s][vic] = (it.command == CMD_WRITE) ? ST_M :
                            (it.directory_has_copy ? ST_S : ST_E);
          r.dir_req_valid = 1'b1;
          r.dir_req_write = it.command == CMD_WRITE;
          r.line_state    = line_st[s][vic];
          touch_way(s, vic);
        end else begin
          r.hit = 1'b1;
          if (it.command == CMD_WRITE) begin
            // shared line asks for ownership
            if (line_st[s][way] == ST_S) begin
              r.dir_req_valid = 1'b1;
              r.dir_req_write = 1'b1;
            end
            line_st[s][way] = ST_M;
          end
          r.line_state = line_st[s][way];
          touch_way(s, way);
        end
      end
      CMD_DOWNGR, CMD_INVAL, CMD_UPGRADE: begin
        if (way == WAYS) begin
          r.error = 1'b1;
        end else begin
          r.hit = 1'b1;
          if (it.command == CMD_DOWNGR) begin
            line_st[s][way] = ST_S;
          end else if (it.command == CMD_INVAL) begin
            line_st[s][way]      = ST_I;
            r.prev_inval_valid   = 1'b1;
            r.prev_inval_address = it.address;
            r.prev_inval_mask    = model_ul_mask;
          end else if (line_st[s][way] == ST_S) begin
            line_st[s][way] = ST_E;
          end else begin
            r.error = 1'b1;
          end
          r.line_state = line_st[s][way];
        end
      end
      CMD_PROBE: begin
        if (way != WAYS) begin
          r.hit        = 1'b1;
          r.line_state = line_st[s][way];
        end else if (line_st[s][vic] != ST_I) begin
          r.evict_valid    = 1'b1;
          r.evict_dirty    = line_st[s][vic] == ST_M;
          r.victim_address = va;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random address: mostly a few tags in a few sets so lines collide and hit
  function automatic logic [31:0] pick_address();
    int sel;
    logic [18:0] t;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    raw = $urandom;
    if (sel == 0) return raw;
    t = (sel == 1) ? 19'h7FFFF - 19'($urandom_range(0, 2)) : 19'($urandom_range(0, 5));
    return {t, 7'($urandom_range(0, 3)), raw[5:0]};
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      it.command = CMD_READ;
    else if (sel < 60) it.command = CMD_WRITE;
    else if (sel < 70) it.command = CMD_DOWNGR;
    else if (sel < 80) it.command = CMD_INVAL;
    else if (sel < 90) it.command = CMD_UPGRADE;
    else if (sel < 98) it.command = CMD_PROBE;
    else               it.command = (sel == 98) ? CMD_UNUSED6 : CMD_UNUSED7;
    it.address = pick_address();
    it.directory_has_copy = 1'($urandom);
    return it;
  endfunction

  // offer one item, optionally after an idle burst; optionally with a typed result
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    bit acc;
    out_item_t pred;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end
    pred = mesi_predict(it);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // then a margin for safety
    repeat (5) @(posedge clk);
  endtask

  // setup cycle then access cycle; the register takes the value when pready is high
  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    bit rdy;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = cfg_pready;
      @(posedge clk);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_CACHE_ID) model_cache_id = value[7:0];
    else if (addr == ADDR_UL_MASK) model_ul_mask = value;
  endtask

  // directed table
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  task automatic add_row(logic [2:0] cmd, logic [31:0] addr, logic dir, bit typed,
                         out_item_t want);
    dir_row_t row;
    row.it.command = cmd;
    row.it.address = addr;
    row.it.directory_has_copy = dir;
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endtask

  // receiver stall: random bursts, one long hold-off on request, none at the end
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check at the falling edge, where both sides are settled
  always @(negedge clk) begin
    accepted_any = (in_valid && !in_stall) || (out_valid && !out_stall);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: %h", $time, out_data);
      end else begin
        out_item_t w;
        w = pending_results.pop_front();
        results_checked++;
        hits_seen   += w.hit;
        evicts_seen += w.evict_valid;
        errors_seen += w.error;
        if (out_data !== w) begin
          fail_count++;
          if (out_data.hit !== w.hit)
            $display("%0t: hit exp %h got %h", $time, w.hit, out_data.hit);
          if (out_data.line_state !== w.line_state)
            $display("%0t: line_state exp %h got %h", $time, w.line_state,
                     out_data.line_state);
          if (out_data.dir_req_valid !== w.dir_req_valid)
            $display("%0t: dir_req_valid exp %h got %h", $time, w.dir_req_valid,
                     out_data.dir_req_valid);
          if (out_data.dir_req_write !== w.dir_req_write)
            $display("%0t: dir_req_write exp %h got %h", $time, w.dir_req_write,
                     out_data.dir_req_write);
          if (out_data.evict_valid !== w.evict_valid)
            $display("%0t: evict_valid exp %h got %h", $time, w.evict_valid,
                     out_data.evict_valid);
          if (out_data.evict_dirty !== w.evict_dirty)
            $display("%0t: evict_dirty exp %h got %h", $time, w.evict_dirty,
                     out_data.evict_dirty);
          if (out_data.victim_address !== w.victim_address)
            $display("%0t: victim_address exp %h got %h", $time, w.victim_address,
                     out_data.victim_address);
          if (out_data.prev_inval_valid !== w.prev_inval_valid)
            $display("%0t: prev_inval_valid exp %h got %h", $time, w.prev_inval_valid,
                     out_data.prev_inval_valid);
          if (out_data.prev_inval_address !== w.prev_inval_address)
            $display("%0t: prev_inval_address exp %h got %h", $time,
                     w.prev_inval_address, out_data.prev_inval_address);
          if (out_data.prev_inval_mask !== w.prev_inval_mask)
            $display("%0t: prev_inval_mask exp %h got %h", $time, w.prev_inval_mask,
                     out_data.prev_inval_mask);
          if (out_data.source_id !== w.source_id)
            $display("%0t: source_id exp %h got %h", $time, w.source_id,
                     out_data.source_id);
          if (out_data.error !== w.error)
            $display("%0t: error exp %h got %h", $time, w.error, out_data.error);
        end
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || accepted_any) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_mesi_cache_line_controller failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_item_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    hits_seen = 0;
    evicts_seen = 0;
    errors_seen = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    accepted_any = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    model_cache_id = '0;
    model_ul_mask = '0;
    // cache copy after reset: all invalid, way i has age i
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        line_tag[s][w] = '0;
        line_st[s][w]  = ST_I;
        line_age[s][w] = 2'(w);
      end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: both registers at their low extreme
    cfg_write(ADDR_CACHE_ID, 32'h0);
    cfg_write(ADDR_UL_MASK, 32'h0);

    // directed: messages on absent lines, the full mesi walk on one line,
    // a clean eviction from a full set, probes, unused commands, address extremes
    add_row(CMD_INVAL, 32'h0, 1'b0, 1'b1, '{0, ST_I, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1});
    add_row(CMD_DOWNGR, 32'h0, 1'b0, 1'b1, '{0, ST_I, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1});
    add_row(CMD_UPGRADE, 32'h0, 1'b0, 1'b1, '{0, ST_I, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1});
    add_row(CMD_PROBE, 32'h0, 1'b0, 1'b1, none);
    add_row(CMD_READ, 32'h0, 1'b0, 1'b1, '{0, ST_E, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row(CMD_READ, 32'h3F, 1'b1, 1'b0, none);
    add_row(CMD_WRITE, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_PROBE, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_DOWNGR, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_WRITE, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_DOWNGR, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_UPGRADE, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_UPGRADE, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_INVAL, 32'h0, 1'b0, 1'b0, none);
    add_row(CMD_READ, 32'h0, 1'b1, 1'b0, none);
    add_row(CMD_WRITE, 32'h2000, 1'b0, 1'b0, none);
    add_row(CMD_WRITE, 32'h4000, 1'b1, 1'b0, none);
    add_row(CMD_READ, 32'h6000, 1'b0, 1'b0, none);
    add_row(CMD_PROBE, 32'hA000, 1'b0, 1'b0, none);
    add_row(CMD_READ, 32'hA000, 1'b0, 1'b0, none);
    add_row(CMD_UNUSED6, 32'hFFFF_FFFF, 1'b1, 1'b1, none);
    add_row(CMD_UNUSED7, 32'h5555_5555, 1'b0, 1'b1, none);
    add_row(CMD_READ, 32'hFFFF_FFFF, 1'b1, 1'b0, none);
    add_row(CMD_WRITE, 32'hFFFF_FFC0, 1'b0, 1'b0, none);
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    // phase 1: registers at their high extreme, one long receiver hold-off
    cfg_write(ADDR_CACHE_ID, 32'hFF);
    cfg_write(ADDR_UL_MASK, 32'hFFFF_FFFF);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n == 100) hold_req = 1'b1;
      send_item(pick_item(), 1'b0, none);
    end
    wait_drained();

    // phase 2: random register values, sender pauses midway until all results are in
    cfg_write(ADDR_CACHE_ID, $urandom);
    cfg_write(ADDR_UL_MASK, $urandom);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n == ITEMS_PER_PHASE / 2) wait_drained();
      send_item(pick_item(), 1'b0, none);
    end
    wait_drained();

    // phase 3: alternating bit patterns, full rate with no idling
    cfg_write(ADDR_CACHE_ID, 32'hA5);
    cfg_write(ADDR_UL_MASK, 32'h5A5A_A5A5);
    no_idle = 1'b1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(pick_item(), 1'b0, none);
    wait_drained();

    $display("run covered %0d commands in four register settings, %0d results checked",
             items_sent, results_checked);
    $display("of those %0d hits, %0d evictions, %0d directory errors",
             hits_seen, evicts_seen, errors_seen);
    if (fail_count == 0) begin
      $display("tb_mesi_cache_line_controller passed");
    end else begin
      $display("tb_mesi_cache_line_controller failed");
    end
    $finish;
  end

endmodule
